### rtl/flp_pkg.sv
// Shared types, widths and constants of the frame peak limiter.
package flp_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 17;
    localparam int COEF_W    = 16;
    localparam int CHAN_W    = 2;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int THR_SH    = 4;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 72;
    localparam int CHANNELS_DEF = 2;

    localparam logic [GAIN_W-1:0] UNITY_GAIN    = 17'h10000;
    localparam logic [GAIN_W-1:0] THR_RESET     = 17'h10000;
    localparam logic [COEF_W-1:0] RELEASE_RESET = 16'd64;
    localparam logic [CHAN_W-1:0] CHAN_RESET    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LIMITER_ON      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SCALE,
        ST_FINISH
    } flp_state_t;

endpackage

### rtl/flp_div.sv
// Restoring divider, one quotient bit per cycle.
module flp_div #(
    parameter int QUO_W = 16,
    parameter int DIV_W = 24,
    parameter int NUM_W = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num_hi,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]   rem_shift;
    logic             fits;

    // partial remainder shifted by one; low dividend bits are all zero
    assign rem_shift = {rem_reg[DIV_W-1:0], 1'b0};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb begin
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = (DIV_W + 1)'(num_hi);
            dsr_next = divisor;
            cnt_next = CNT_W'(QUO_W);
        end else if (cnt_reg != '0) begin
            rem_next = fits ? rem_shift - {1'b0, dsr_reg} : rem_shift;
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

### rtl/flp_smul.sv
// Shift-add multiplier: signed multiplicand times unsigned multiplier, one bit per cycle.
module flp_smul #(
    parameter int A_W = 24,
    parameter int B_W = 17
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [A_W-1:0]   mcand,
    input  logic [B_W-1:0]          mplier,
    output logic                    busy,
    output logic signed [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic signed [P_W-1:0] acc_reg, acc_next;
    logic signed [P_W-1:0] mc_reg, mc_next;
    logic [B_W-1:0]        mp_reg, mp_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    always_comb begin
        acc_next = acc_reg;
        mc_next  = mc_reg;
        mp_next  = mp_reg;
        cnt_next = cnt_reg;
        if (start) begin
            acc_next = '0;
            mc_next  = P_W'(mcand);
            mp_next  = mplier;
            cnt_next = CNT_W'(B_W);
        end else if (cnt_reg != '0) begin
            if (mp_reg[0]) begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign busy    = cnt_reg != '0;
    assign product = acc_reg;

endmodule

### rtl/frame_peak_limiter.sv
// Frame peak limiter top level: config registers, sequencer, serial arithmetic units.
//
// Usage:
//   s_ channel takes one frame: sample_0 and sample_1 (signed Q3.20) in s_tdata.
//   m_ channel returns limited_0, limited_1 and applied_gain (Q1.16) in m_tdata.
//   cfg_wr_en/cfg_addr/cfg_wdata write limiter_on, threshold_gain, release_coef
//   and active_channels; write them only while no item is in flight.
// Timing:
//   One item is in work at a time. After acceptance the serial divider (target
//   gain) and the serial release multiplier run side by side, then the serial
//   sample multipliers run; the result is loaded into the output register and
//   the next item is taken once the sequencer is back in idle.
//   The result sits in an output register, so s_tready returns while an earlier
//   result still waits; if m_tready stays low the finished item waits in place
//   and s_tready stays low until the output register frees.
// Reset:
//   aresetn (synchronous) clears m_tvalid, returns gain to unity and loads the
//   register defaults: limiter off, threshold unity, release 64, two channels.
module frame_peak_limiter #(
    parameter int CHANNELS = flp_pkg::CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [23:0] sample_0, [47:24] sample_1
    input  logic [flp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [23:0] limited_0, [47:24] limited_1, [64:48] applied_gain, [71:65] zero
    output logic [flp_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [flp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [flp_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int SW   = flp_pkg::SAMPLE_W;
    localparam int GW   = flp_pkg::GAIN_W;
    localparam int CW   = flp_pkg::COEF_W;
    localparam int NW   = GW + flp_pkg::THR_SH;
    localparam int RA_W = GW + 1;
    localparam int RP_W = RA_W + CW;
    localparam int SP_W = SW + GW;
    localparam int PAD_W = flp_pkg::M_DATA_W - 2 * SW - GW;

    // configuration
    logic                         on_reg;
    logic [GW-1:0]                thr_reg;
    logic [CW-1:0]                rc_reg;
    logic [flp_pkg::CHAN_W-1:0]   ac_reg;

    flp_pkg::flp_state_t state_reg, state_next;

    logic [GW-1:0]         gain_reg, gain_next;
    logic signed [SW-1:0]  s0_reg, s1_reg;
    logic [SW-1:0]         peak_reg;
    logic signed [SW-1:0]  lim0_reg, lim1_reg;
    logic [GW-1:0]         out_gain_reg;
    logic                  m_valid_reg;

    logic                  stereo;
    logic signed [SW-1:0]  in_s0, in_s1;
    logic [SW-1:0]         mag0, mag1, peak_in;
    logic                  accept, start_scale, load_out, calc_done;

    logic                  div_busy, rel_busy, sc0_busy, sc1_busy;
    logic [CW-1:0]         quo;
    logic signed [RP_W-1:0] rel_prod;
    logic signed [SP_W-1:0] sc0_prod, sc1_prod;
    logic [GW-1:0]         unity_gap;

    logic                  over;
    logic [GW-1:0]         target;
    logic [GW:0]           rel_sum;
    logic [RP_W-1:0]       rel_round;
    logic [GW-1:0]         rel_gain;

    assign stereo  = (CHANNELS >= 2) && ac_reg[1];
    assign in_s0   = s_tdata[SW-1:0];
    assign in_s1   = stereo ? s_tdata[2*SW-1:SW] : '0;
    assign mag0    = in_s0[SW-1] ? SW'(-in_s0) : SW'(in_s0);
    assign mag1    = in_s1[SW-1] ? SW'(-in_s1) : SW'(in_s1);
    assign peak_in = (mag1 > mag0) ? mag1 : mag0;
    assign unity_gap = flp_pkg::UNITY_GAIN - gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg  <= 1'b0;
            thr_reg <= flp_pkg::THR_RESET;
            rc_reg  <= flp_pkg::RELEASE_RESET;
            ac_reg  <= flp_pkg::CHAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                flp_pkg::REG_LIMITER_ON:      on_reg  <= cfg_wdata[0];
                flp_pkg::REG_THRESHOLD_GAIN:  thr_reg <= cfg_wdata[GW-1:0];
                flp_pkg::REG_RELEASE_COEF:    rc_reg  <= cfg_wdata[CW-1:0];
                flp_pkg::REG_ACTIVE_CHANNELS: ac_reg  <= cfg_wdata[flp_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // target gain = threshold * 2^20 / peak
    flp_div #(
        .QUO_W (CW),
        .DIV_W (SW),
        .NUM_W (NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .num_hi   ({thr_reg, {flp_pkg::THR_SH{1'b0}}}),
        .divisor  (peak_in),
        .busy     (div_busy),
        .quotient (quo)
    );

    // release product (unity - gain) * release_coef
    flp_smul #(
        .A_W (RA_W),
        .B_W (CW)
    ) u_rel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mcand   ({1'b0, unity_gap}),
        .mplier  (rc_reg),
        .busy    (rel_busy),
        .product (rel_prod)
    );

    assign calc_done = !div_busy && !rel_busy;

    always_comb begin
        over      = peak_reg > SW'({thr_reg, {flp_pkg::THR_SH{1'b0}}});
        target    = over ? {1'b0, quo} : flp_pkg::UNITY_GAIN;
        // round the release step up so the gain can reach unity
        rel_round = RP_W'($unsigned(rel_prod)) + RP_W'(17'h0FFFF);
        rel_sum   = (GW + 1)'(gain_reg) + (GW + 1)'(rel_round[RP_W-2:flp_pkg::FRAC_W]);
        rel_gain  = rel_sum[GW-1:0];
        if (!on_reg) begin
            gain_next = flp_pkg::UNITY_GAIN;
        end else if (target < gain_reg) begin
            gain_next = target;
        end else if (rel_gain > target) begin
            gain_next = target;
        end else begin
            gain_next = rel_gain;
        end
    end

    flp_smul #(
        .A_W (SW),
        .B_W (GW)
    ) u_scale0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_scale),
        .mcand   (s0_reg),
        .mplier  (gain_next),
        .busy    (sc0_busy),
        .product (sc0_prod)
    );

    generate
        if (CHANNELS >= 2) begin : g_lane1
            flp_smul #(
                .A_W (SW),
                .B_W (GW)
            ) u_scale1 (
                .aclk    (aclk),
                .aresetn (aresetn),
                .start   (start_scale),
                .mcand   (s1_reg),
                .mplier  (gain_next),
                .busy    (sc1_busy),
                .product (sc1_prod)
            );
        end else begin : g_mono
            assign sc1_busy = 1'b0;
            assign sc1_prod = '0;
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            flp_pkg::ST_IDLE:   if (s_tvalid) state_next = flp_pkg::ST_CALC;
            flp_pkg::ST_CALC:   if (calc_done) state_next = flp_pkg::ST_SCALE;
            flp_pkg::ST_SCALE:  if (!sc0_busy && !sc1_busy) state_next = flp_pkg::ST_FINISH;
            flp_pkg::ST_FINISH: if (!m_valid_reg || m_tready) state_next = flp_pkg::ST_IDLE;
            default:            state_next = flp_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready    = 1'b0;
        start_scale = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            flp_pkg::ST_IDLE:   s_tready = 1'b1;
            flp_pkg::ST_CALC:   start_scale = calc_done;
            flp_pkg::ST_SCALE:  ;
            flp_pkg::ST_FINISH: load_out = !m_valid_reg || m_tready;
            default:            ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= flp_pkg::ST_IDLE;
            gain_reg    <= flp_pkg::UNITY_GAIN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (start_scale) begin
                gain_reg <= gain_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            s0_reg   <= in_s0;
            s1_reg   <= in_s1;
            peak_reg <= peak_in;
        end
        if (load_out) begin
            // floor of product / 65536
            lim0_reg     <= sc0_prod[SW+flp_pkg::FRAC_W-1:flp_pkg::FRAC_W];
            lim1_reg     <= sc1_prod[SW+flp_pkg::FRAC_W-1:flp_pkg::FRAC_W];
            out_gain_reg <= gain_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_gain_reg, lim1_reg, lim0_reg};

endmodule

### rtl/flp_chk.sv
// Port-level checker for the frame peak limiter, bound to the top level.
module flp_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [flp_pkg::M_DATA_W-1:0] m_tdata
);

    // a result must wait in place while the receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // gain never exceeds unity, padding stays zero
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64:48] <= 17'h10000) && (m_tdata[71:65] == 7'd0))
        else $error("applied gain out of range");

endmodule

bind frame_peak_limiter flp_chk u_flp_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
